// ===== rtl/rbsi_pkg.sv =====
// Shared widths, types and register addresses of the ray versus box slab test.
`timescale 1ns / 1ps
package rbsi_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int THR_W = 16;
  localparam int OUT_W = 32;
  localparam int NUM_AXES = 3;
  localparam int NUM_LANES = 2 * NUM_AXES;
  localparam int MAG_W = COORD_W + 1;
  localparam int NUM_W = MAG_W + FRAC_W;
  localparam int DEN_W = COORD_W;
  localparam int TIME_W = NUM_W + 1;
  localparam int PADDR_W = 1;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-1:0] ADDR_PARALLEL_THRESHOLD = '0;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef logic [NUM_AXES-1:0][COORD_W-1:0] coord_vec_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] quo;
  } lane_t;

  typedef lane_t [NUM_LANES-1:0] lane_vec_t;

  typedef struct packed {
    logic valid;
    logic pmiss;
    logic [NUM_AXES-1:0] par;
    logic [NUM_AXES-1:0] dneg;
    logic [NUM_LANES-1:0] qneg;
  } side_t;

endpackage

// ===== rtl/rbsi_front.sv =====
// Input stage: slab differences, magnitudes, parallel checks and divider setup.
`timescale 1ns / 1ps
module rbsi_front import rbsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  coord_vec_t       origin,
  input  coord_vec_t       dir,
  input  coord_vec_t       box_low,
  input  coord_vec_t       box_high,
  input  logic [THR_W-1:0] threshold,
  output lane_vec_t        lanes,
  output side_t            side
);

  lane_vec_t lanes_next;
  side_t     side_next;

  always_comb begin
    logic signed [MAG_W-1:0] dl;
    logic signed [MAG_W-1:0] dh;
    logic [MAG_W-1:0]        ml;
    logic [MAG_W-1:0]        mh;
    logic [DEN_W-1:0]        dm;
    logic                    par;
    side_next = '0;
    side_next.valid = in_valid;
    for (int a = 0; a < NUM_AXES; a++) begin
      dl = $signed({box_low[a][COORD_W-1], box_low[a]})
           - $signed({origin[a][COORD_W-1], origin[a]});
      dh = $signed({box_high[a][COORD_W-1], box_high[a]})
           - $signed({origin[a][COORD_W-1], origin[a]});
      ml = dl[MAG_W-1] ? MAG_W'(-dl) : MAG_W'(dl);
      mh = dh[MAG_W-1] ? MAG_W'(-dh) : MAG_W'(dh);
      dm = dir[a][COORD_W-1] ? DEN_W'(-dir[a]) : dir[a];
      par = (dir[a] == '0) || (dm < DEN_W'(threshold));
      side_next.par[a] = par;
      side_next.dneg[a] = dir[a][COORD_W-1];
      side_next.qneg[2*a] = dl[MAG_W-1] ^ dir[a][COORD_W-1];
      side_next.qneg[2*a+1] = dh[MAG_W-1] ^ dir[a][COORD_W-1];
      if (par && (($signed(origin[a]) < $signed(box_low[a]))
                  || ($signed(origin[a]) > $signed(box_high[a])))) begin
        side_next.pmiss = 1'b1;
      end
      lanes_next[2*a].num = {ml, FRAC_W'(0)};
      lanes_next[2*a+1].num = {mh, FRAC_W'(0)};
      for (int k = 0; k < 2; k++) begin
        lanes_next[2*a+k].rem = '0;
        lanes_next[2*a+k].quo = '0;
        lanes_next[2*a+k].den = par ? DEN_W'(1) : dm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else if (en) begin
      side <= side_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes <= lanes_next;
    end
  end

endmodule

// ===== rtl/rbsi_div_cell.sv =====
// One restoring division step for all six slab lanes, registered.
`timescale 1ns / 1ps
module rbsi_div_cell import rbsi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  lane_vec_t lanes_in,
  input  side_t     side_in,
  output lane_vec_t lanes_out,
  output side_t     side_out
);

  lane_vec_t lanes_next;

  always_comb begin
    logic [DEN_W:0] trial;
    for (int l = 0; l < NUM_LANES; l++) begin
      trial = {lanes_in[l].rem, lanes_in[l].num[NUM_W-1]};
      lanes_next[l].den = lanes_in[l].den;
      lanes_next[l].num = {lanes_in[l].num[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, lanes_in[l].den}) begin
        lanes_next[l].rem = DEN_W'(trial - {1'b0, lanes_in[l].den});
        lanes_next[l].quo = {lanes_in[l].quo[NUM_W-2:0], 1'b1};
      end else begin
        lanes_next[l].rem = DEN_W'(trial);
        lanes_next[l].quo = {lanes_in[l].quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_out <= lanes_next;
    end
  end

endmodule

// ===== rtl/rbsi_fold.sv =====
// Output stage: signs the slab times, folds entry and exit, and forms the result.
`timescale 1ns / 1ps
module rbsi_fold import rbsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  lane_vec_t        lanes,
  input  side_t            side,
  output logic             out_valid,
  output logic             hit,
  output logic [OUT_W-1:0] entry_time,
  output logic             starts_inside
);

  logic             hit_next;
  logic [OUT_W-1:0] entry_next;
  logic             starts_next;

  always_comb begin
    logic signed [TIME_W-1:0] tl;
    logic signed [TIME_W-1:0] th;
    logic signed [TIME_W-1:0] tmin;
    logic signed [TIME_W-1:0] tmax;
    tmin = {1'b1, {(TIME_W-1){1'b0}}};
    tmax = {1'b0, {(TIME_W-1){1'b1}}};
    for (int a = 0; a < NUM_AXES; a++) begin
      tl = side.qneg[2*a] ? -$signed({1'b0, lanes[2*a].quo})
                          : $signed({1'b0, lanes[2*a].quo});
      th = side.qneg[2*a+1] ? -$signed({1'b0, lanes[2*a+1].quo})
                            : $signed({1'b0, lanes[2*a+1].quo});
      if (!side.par[a]) begin
        if (side.dneg[a]) begin
          if (th > tmin) tmin = th;
          if (tl < tmax) tmax = tl;
        end else begin
          if (tl > tmin) tmin = tl;
          if (th < tmax) tmax = th;
        end
      end
    end
    hit_next = !side.pmiss && (tmin <= tmax) && !tmax[TIME_W-1];
    entry_next = '0;
    starts_next = 1'b0;
    if (hit_next) begin
      if (tmin <= 0) begin
        starts_next = 1'b1;
      end else if (|tmin[TIME_W-1:OUT_W]) begin
        entry_next = '1;
      end else begin
        entry_next = tmin[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
      entry_time <= entry_next;
      starts_inside <= starts_next;
    end
  end

endmodule

// ===== rtl/ray_box_slab_intersection_core.sv =====
// Top level of the ray versus axis-aligned box slab test with its register port.
`timescale 1ns / 1ps
// The core takes one ray test per clock while the output is not stalled, and
// returns one beat per test, in order. It has one setup stage, a row of 49
// division cells that each produce one quotient bit of all six slab times,
// and one folding stage that also holds the output. When the output is held
// by a stalled consumer the whole row stops and in_ready drops.
module ray_box_slab_intersection_core import rbsi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [COORD_W-1:0]  origin_x,
  input  logic [COORD_W-1:0]  origin_y,
  input  logic [COORD_W-1:0]  origin_z,
  input  logic [COORD_W-1:0]  dir_x,
  input  logic [COORD_W-1:0]  dir_y,
  input  logic [COORD_W-1:0]  dir_z,
  input  logic [COORD_W-1:0]  box_low_x,
  input  logic [COORD_W-1:0]  box_low_y,
  input  logic [COORD_W-1:0]  box_low_z,
  input  logic [COORD_W-1:0]  box_high_x,
  input  logic [COORD_W-1:0]  box_high_y,
  input  logic [COORD_W-1:0]  box_high_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic [OUT_W-1:0]    entry_time,
  output logic                starts_inside
);

  logic [THR_W-1:0] parallel_threshold;
  logic             adv;
  coord_vec_t       origin;
  coord_vec_t       dir;
  coord_vec_t       box_low;
  coord_vec_t       box_high;
  lane_vec_t        lane_chain [NUM_W+1];
  side_t            side_chain [NUM_W+1];

  assign pready = 1'b1;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_threshold <= THR_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_PARALLEL_THRESHOLD) begin
      parallel_threshold <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_PARALLEL_THRESHOLD: prdata = PDATA_W'(parallel_threshold);
      default:                 prdata = '0;
    endcase
  end

  assign origin = {origin_z, origin_y, origin_x};
  assign dir = {dir_z, dir_y, dir_x};
  assign box_low = {box_low_z, box_low_y, box_low_x};
  assign box_high = {box_high_z, box_high_y, box_high_x};

  rbsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (in_valid),
    .origin    (origin),
    .dir       (dir),
    .box_low   (box_low),
    .box_high  (box_high),
    .threshold (parallel_threshold),
    .lanes     (lane_chain[0]),
    .side      (side_chain[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    rbsi_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .lanes_in  (lane_chain[i]),
      .side_in   (side_chain[i]),
      .lanes_out (lane_chain[i+1]),
      .side_out  (side_chain[i+1])
    );
  end

  rbsi_fold u_fold (
    .clk           (clk),
    .rst           (rst),
    .en            (adv),
    .lanes         (lane_chain[NUM_W]),
    .side          (side_chain[NUM_W]),
    .out_valid     (out_valid),
    .hit           (hit),
    .entry_time    (entry_time),
    .starts_inside (starts_inside)
  );

endmodule

// ===== tb/ray_box_slab_intersection_core_tb.sv =====
// Self-checking testbench of the ray versus box slab test core.
`timescale 1ns / 1ps
module ray_box_slab_intersection_core_tb;
  import rbsi_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] org [3];
    logic [COORD_W-1:0] dir [3];
    logic [COORD_W-1:0] lo [3];
    logic [COORD_W-1:0] hi [3];
  } ray_test_t;

  typedef struct {
    logic hit;
    logic [OUT_W-1:0] entry;
    logic in_box;
  } hit_info_t;

  typedef struct {
    ray_test_t rt;
    logic known;
    hit_info_t res;
  } stim_row_t;

  localparam longint TIME_CAP = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MAXN = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam int LATENCY = 51;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic [COORD_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic [COORD_W-1:0] box_low_x = '0, box_low_y = '0, box_low_z = '0;
  logic [COORD_W-1:0] box_high_x = '0, box_high_y = '0, box_high_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [OUT_W-1:0] entry_time;
  logic starts_inside;

  logic [THR_W-1:0] thr_model = THR_RESET;
  hit_info_t expected_hits [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_off = 1'b0;
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int hits_seen = 0;

  ray_box_slab_intersection_core u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint signed slab_time(longint signed diff, longint signed d);
    longint unsigned n, dv, q, r;
    n = diff < 0 ? -diff : diff;
    dv = d < 0 ? -d : d;
    q = n / dv;
    r = n % dv;
    if (q > (TIME_CAP >> FRAC_W)) begin
      q = TIME_CAP;
    end else begin
      for (int i = 0; i < FRAC_W; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= dv) begin
          r = r - dv;
          q = q | 1;
        end
      end
      if (q > TIME_CAP) q = TIME_CAP;
    end
    return ((diff < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic hit_info_t predict_hit(ray_test_t rt);
    longint signed tmin, tmax, o, d, lo, hi, t1, t2, t;
    logic met;
    hit_info_t res;
    tmin = 64'sh8000_0000_0000_0000;
    tmax = 64'sh7FFF_FFFF_FFFF_FFFF;
    met = 1'b1;
    for (int a = 0; a < 3 && met; a++) begin
      o = longint'(signed'(rt.org[a]));
      d = longint'(signed'(rt.dir[a]));
      lo = longint'(signed'(rt.lo[a]));
      hi = longint'(signed'(rt.hi[a]));
      if (d == 0 || (d < 0 ? -d : d) < longint'(thr_model)) begin
        if (o < lo || o > hi) met = 1'b0;
      end else begin
        t1 = slab_time(lo - o, d);
        t2 = slab_time(hi - o, d);
        if (d < 0) begin
          t = t1;
          t1 = t2;
          t2 = t;
        end
        if (t1 > tmin) tmin = t1;
        if (t2 < tmax) tmax = t2;
        if (tmin > tmax) met = 1'b0;
      end
    end
    if (met && tmax < 0) met = 1'b0;
    res.hit = met;
    res.in_box = met && tmin <= 0;
    res.entry = 0;
    if (met && tmin > 0) res.entry = tmin > 64'hFFFF_FFFF ? '1 : OUT_W'(tmin);
    return res;
  endfunction

  task automatic write_threshold(logic [THR_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_PARALLEL_THRESHOLD;
    pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thr_model = v;
  endtask

  task automatic send_test(ray_test_t rt, logic known, hit_info_t res);
    hit_info_t e;
    logic taken;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    {origin_x, origin_y, origin_z} <= {rt.org[0], rt.org[1], rt.org[2]};
    {dir_x, dir_y, dir_z} <= {rt.dir[0], rt.dir[1], rt.dir[2]};
    {box_low_x, box_low_y, box_low_z} <= {rt.lo[0], rt.lo[1], rt.lo[2]};
    {box_high_x, box_high_y, box_high_z} <= {rt.hi[0], rt.hi[1], rt.hi[2]};
    in_valid <= 1'b1;
    if (known) begin
      e = res;
    end else begin
      e = predict_hit(rt);
    end
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    expected_hits.push_back(e);
    beats_in++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(3) == 0 ? MAXN : MAXP;
      2: return 32'($signed($urandom_range(40)) - 20) <<< 16;
      3: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
      if (out_valid && out_ready) begin
        beats_out++;
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: hit=%0b entry=%h", hit, entry_time);
        end else begin
          hit_info_t e;
          e = expected_hits.pop_front();
          if (hit)
            hits_seen++;
          if (hit !== e.hit || entry_time !== e.entry || starts_inside !== e.in_box) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hit=%0b entry=%h in=%0b, got hit=%0b entry=%h in=%0b",
                       e.hit, e.entry, e.in_box, hit, entry_time, starts_inside);
          end
        end
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    ray_test_t rt;
    hit_info_t none;
    int unsigned thr_set [5];
    none = '{hit: 1'b0, entry: '0, in_box: 1'b0};
    thr_set = '{16'hFFFF, 0, 300, 16'h8000, 1};

    // Unit box from 0 to 1 on each axis, ray along +x from -1: entry 1.0.
    row.rt.org = '{-ONE, 32'h8000, 32'h8000};
    row.rt.dir = '{ONE, 0, 0};
    row.rt.lo = '{0, 0, 0};
    row.rt.hi = '{ONE, ONE, ONE};
    row.known = 1'b1;
    row.res = '{hit: 1'b1, entry: ONE, in_box: 1'b0};
    rows.push_back(row);
    // Origin inside the box.
    row.rt.org = '{32'h8000, 32'h8000, 32'h8000};
    row.res = '{hit: 1'b1, entry: 0, in_box: 1'b1};
    rows.push_back(row);
    // All axes parallel and inside.
    row.rt.dir = '{0, 0, 0};
    rows.push_back(row);
    // Parallel and outside the slab.
    row.rt.org = '{32'h8000, 2 * ONE, 32'h8000};
    row.res = none;
    rows.push_back(row);
    // Box behind the ray.
    row.rt.org = '{2 * ONE, 32'h8000, 32'h8000};
    row.rt.dir = '{ONE, 0, 0};
    rows.push_back(row);
    // Parallel on the inclusive bound.
    row.rt.org = '{32'h8000, ONE, 0};
    row.rt.dir = '{0, 0, 0};
    row.res = '{hit: 1'b1, entry: 0, in_box: 1'b1};
    rows.push_back(row);
    // Saturating entry: tiny direction, far box.
    row.rt.org = '{MAXN, 0, 0};
    row.rt.dir = '{1, 0, 0};
    row.rt.lo = '{MAXP, 0, 0};
    row.rt.hi = '{MAXP, 0, 0};
    row.res = '{hit: 1'b1, entry: '1, in_box: 1'b0};
    rows.push_back(row);
    // Rows checked by the predictor: extremes, negatives, inverted box, empty interval.
    row.known = 1'b0;
    row.rt = '{org: '{MAXP, MAXN, MAXP}, dir: '{MAXN, MAXP, MAXN},
               lo: '{MAXN, MAXN, MAXN}, hi: '{MAXP, MAXP, MAXP}};
    rows.push_back(row);
    row.rt = '{org: '{2 * ONE, 2 * ONE, 2 * ONE}, dir: '{-ONE, -ONE, -ONE},
               lo: '{0, 0, 0}, hi: '{ONE, ONE, ONE}};
    rows.push_back(row);
    row.rt = '{org: '{-ONE, -ONE, 0}, dir: '{ONE, -ONE, 0},
               lo: '{0, 0, 0}, hi: '{ONE, ONE, ONE}};
    rows.push_back(row);
    row.rt = '{org: '{0, 0, 0}, dir: '{ONE, 3 * ONE, 32'hFFFF_0001},
               lo: '{ONE, -ONE, -ONE}, hi: '{0, ONE, ONE}};
    rows.push_back(row);
    row.rt = '{org: '{MAXN, MAXP, 32'hFFFF_FFFF}, dir: '{32'hFFFF_FFFF, 1, MAXP},
               lo: '{MAXP, MAXN, 0}, hi: '{MAXN, MAXP, 32'hFFFF_FFFF}};
    rows.push_back(row);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_test(rows[i].rt, rows[i].known, rows[i].res);
    drain_and_settle();

    for (int phase = 0; phase < 5; phase++) begin
      write_threshold(THR_W'(thr_set[phase]));
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 85; end
        3: begin send_idle_pct = 13; recv_stall_pct = 13; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (phase == 4) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (200) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 120; n++) begin
        for (int a = 0; a < 3; a++) begin
          logic [31:0] p, q;
          rt.org[a] = rand_coord();
          rt.dir[a] = rand_coord();
          p = rand_coord();
          q = rand_coord();
          // Mostly well-ordered boxes, some inverted.
          if ($urandom_range(9) != 0 && $signed(p) > $signed(q)) begin
            rt.lo[a] = q;
            rt.hi[a] = p;
          end else begin
            rt.lo[a] = p;
            rt.hi[a] = q;
          end
        end
        send_test(rt, 1'b0, none);
      end
      drain_and_settle();
    end

    $display("Ran %0d ray tests over 5 threshold settings, %0d hits observed.",
             beats_in, hits_seen);
    if (mismatches == 0 && beats_out == beats_in) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
